// ----- rtl/sstf_pkg.sv -----
// sstf_pkg: shared types and constants of the shortest-seek-first scheduler
// no dependencies; used by the cell, the top level and the checker
package sstf_pkg;

   localparam int OWNER_W    = 4;
   localparam int TRACK_IN_W = 16;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_FINISH  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_QUEUE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] MAX_QUEUE_RST = 5'd16;
   localparam logic [CFG_W-1:0] REQ_COUNT_RST = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // search token control travelling down the cell row
   typedef struct packed {
      logic valid;
      logic found;
   } scan_ctl_type;

endpackage

// ----- rtl/sstf_disk_request_scheduler_unit.sv -----
// sstf_disk_request_scheduler_unit: top level of the shortest-seek-first disk scheduler
// depends on sstf_pkg and sstf_cell
//
// req channel: one request per handshake; req_tuser is the opcode (request or
// requester finished), req_tdata carries requester id and track. rsp channel:
// one served request per handshake, rsp_tlast marks the final service caused
// by an input. csr channel writes the queue limit (index 0) and the starting
// requester count (index 1); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. The queue is a row of
// QUEUE_DEPTH cells. A service sends a search token down the row, one cell per
// cycle, then removes the winner by shifting the younger cells one place toward
// the head of the row. An input that serves nothing goes from check back to idle;
// each service runs check, the token walk through the row ending in capture, and emit.
// An input is taken only when the previous one has finished all its services.
// A finished result waits in the output register; if rsp_tready stays low the
// next service stops at its emit step until the register frees.
// Reset clears the queue, the head track and the finished count and sets both
// registers to 16; no clearing pass is needed.
module sstf_disk_request_scheduler_unit #(
   parameter int QUEUE_DEPTH    = 16,
   parameter int MAX_REQUESTERS = 16,
   parameter int TRACK_BITS     = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sstf_pkg::REQ_DATA_W-1:0]    req_tdata,   // requester[3:0], track_number[19:4]
   input  logic                               req_tuser,   // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sstf_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // served_requester[3:0], served_track[19:4]
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sstf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sstf_pkg::CFG_W-1:0]         csr_data
);

   localparam int TW    = (TRACK_BITS < sstf_pkg::TRACK_IN_W) ? TRACK_BITS
                                                              : sstf_pkg::TRACK_IN_W;
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OW    = sstf_pkg::OWNER_W;
   localparam int CW    = sstf_pkg::CFG_W;

   sstf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TW-1:0]       head_ff, head_in;
   logic [CW-1:0]       fin_ff, fin_in;
   logic [CW-1:0]       maxq_ff, reqcnt_ff;
   logic [IDX_W-1:0]    win_idx_ff, win_idx_in;
   logic [TW-1:0]       win_track_ff, win_track_in;
   logic [OW-1:0]       win_owner_ff, win_owner_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]       rsp_owner_ff, rsp_owner_in;
   logic [TW-1:0]       rsp_track_ff, rsp_track_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]    limit;
   logic [CW-1:0]       req_eff;
   logic [CW-1:0]       live;
   logic                req_fire;
   logic                ins_en;
   logic                remove_en;
   logic                start;
   logic                out_free;
   logic [CNT_W-1:0]    count_dec;
   logic [TW-1:0]       in_track;
   logic [OW-1:0]       in_owner;

   sstf_pkg::scan_ctl_type ctl [QUEUE_DEPTH+1];
   logic [TW-1:0]          best_dist [QUEUE_DEPTH+1];
   logic [IDX_W-1:0]       idx  [QUEUE_DEPTH+1];
   logic [TW-1:0]          btrk [QUEUE_DEPTH+1];
   logic [OW-1:0]          bown [QUEUE_DEPTH+1];
   logic [TW-1:0]          e_track [QUEUE_DEPTH];
   logic [OW-1:0]          e_owner [QUEUE_DEPTH];

   function automatic logic serve_ok(input logic [CNT_W-1:0] cnt, input logic [CW-1:0] lv,
                                     input logic [CNT_W-1:0] lim);
      serve_ok = (cnt != '0) &&
                 ((lv == '0) || (int'(cnt) >= int'(lv)) || (int'(cnt) >= int'(lim)));
   endfunction

   assign in_owner = req_tdata[OW-1:0];
   assign in_track = TW'(req_tdata[OW +: sstf_pkg::TRACK_IN_W]);

   always_comb begin
      if (maxq_ff == '0) begin
         limit = CNT_W'(1);
      end else if (int'(maxq_ff) > QUEUE_DEPTH) begin
         limit = CNT_W'(QUEUE_DEPTH);
      end else begin
         limit = CNT_W'(maxq_ff);
      end
      req_eff = (int'(reqcnt_ff) > MAX_REQUESTERS) ? CW'(MAX_REQUESTERS) : reqcnt_ff;
      live    = (fin_ff < req_eff) ? (req_eff - fin_ff) : '0;
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxq_ff   <= sstf_pkg::MAX_QUEUE_RST;
         reqcnt_ff <= sstf_pkg::REQ_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sstf_pkg::CSR_MAX_QUEUE: maxq_ff   <= csr_data;
            sstf_pkg::CSR_REQ_COUNT: reqcnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // cell row
   assign ctl[0].valid = start;
   assign ctl[0].found = 1'b0;
   assign best_dist[0] = '0;
   assign idx[0]       = '0;
   assign btrk[0]      = '0;
   assign bown[0]      = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          occ, wr, sh;
      logic [TW-1:0] nt;
      logic [OW-1:0] no;

      assign occ = CNT_W'(i) < count_ff;
      assign wr  = ins_en && (CNT_W'(i) == count_ff);
      if (i < QUEUE_DEPTH - 1) begin : g_mid
         assign sh = remove_en && (IDX_W'(i) >= win_idx_ff);
         assign nt = e_track[i+1];
         assign no = e_owner[i+1];
      end else begin : g_end
         assign sh = 1'b0;
         assign nt = e_track[i];
         assign no = e_owner[i];
      end

      sstf_cell #(
         .TW         (TW),
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .head        (head_ff),
         .occupied    (occ),
         .wr_en       (wr),
         .wr_track    (in_track),
         .wr_owner    (in_owner),
         .shift_en    (sh),
         .nxt_track   (nt),
         .nxt_owner   (no),
         .entry_track (e_track[i]),
         .entry_owner (e_owner[i]),
         .ctl_in      (ctl[i]),
         .dist_in     (best_dist[i]),
         .idx_in      (idx[i]),
         .track_in    (btrk[i]),
         .owner_in    (bown[i]),
         .ctl_out     (ctl[i+1]),
         .dist_out    (best_dist[i+1]),
         .idx_out     (idx[i+1]),
         .track_out   (btrk[i+1]),
         .owner_out   (bown[i+1])
      );
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstf_pkg::ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         fin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_idx_ff   <= win_idx_in;
      win_track_ff <= win_track_in;
      win_owner_ff <= win_owner_in;
      rsp_owner_ff <= rsp_owner_in;
      rsp_track_ff <= rsp_track_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == sstf_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_dec  = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      fin_in       = fin_ff;
      win_idx_in   = win_idx_ff;
      win_track_in = win_track_ff;
      win_owner_in = win_owner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_owner_in = rsp_owner_ff;
      rsp_track_in = rsp_track_ff;
      rsp_last_in  = rsp_last_ff;
      ins_en       = 1'b0;
      remove_en    = 1'b0;
      start        = 1'b0;
      unique case (state_ff)
         sstf_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == sstf_pkg::OP_REQUEST) begin
                  if (count_ff < limit) begin
                     ins_en   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (live != '0) begin
                  fin_in = fin_ff + CW'(1);
               end
               state_in = sstf_pkg::ST_CHECK;
            end
         end
         sstf_pkg::ST_CHECK: begin
            if (serve_ok(count_ff, live, limit)) begin
               start    = 1'b1;
               state_in = sstf_pkg::ST_SCAN;
            end else begin
               state_in = sstf_pkg::ST_IDLE;
            end
         end
         sstf_pkg::ST_SCAN: begin
            if (ctl[QUEUE_DEPTH].valid) begin
               win_idx_in   = idx[QUEUE_DEPTH];
               win_track_in = btrk[QUEUE_DEPTH];
               win_owner_in = bown[QUEUE_DEPTH];
               state_in     = sstf_pkg::ST_EMIT;
            end
         end
         sstf_pkg::ST_EMIT: begin
            if (out_free) begin
               remove_en    = 1'b1;
               count_in     = count_dec;
               head_in      = win_track_ff;
               rsp_valid_in = 1'b1;
               rsp_owner_in = win_owner_ff;
               rsp_track_in = win_track_ff;
               rsp_last_in  = !serve_ok(count_dec, live, limit);
               state_in     = sstf_pkg::ST_CHECK;
            end
         end
         default: state_in = sstf_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(sstf_pkg::RSP_DATA_W - OW - sstf_pkg::TRACK_IN_W){1'b0}},
                        sstf_pkg::TRACK_IN_W'(rsp_track_ff), rsp_owner_ff};

endmodule

// ----- rtl/sstf_cell.sv -----
// sstf_cell: one queue slot of the scheduler and one stage of the nearest-track search
// depends on sstf_pkg
module sstf_cell #(
   parameter int TW         = 16,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TW-1:0]              head,
   input  logic                       occupied,
   input  logic                       wr_en,
   input  logic [TW-1:0]              wr_track,
   input  logic [sstf_pkg::OWNER_W-1:0] wr_owner,
   input  logic                       shift_en,
   input  logic [TW-1:0]              nxt_track,
   input  logic [sstf_pkg::OWNER_W-1:0] nxt_owner,
   output logic [TW-1:0]              entry_track,
   output logic [sstf_pkg::OWNER_W-1:0] entry_owner,
   input  sstf_pkg::scan_ctl_type     ctl_in,
   input  logic [TW-1:0]              dist_in,
   input  logic [IDX_W-1:0]           idx_in,
   input  logic [TW-1:0]              track_in,
   input  logic [sstf_pkg::OWNER_W-1:0] owner_in,
   output sstf_pkg::scan_ctl_type     ctl_out,
   output logic [TW-1:0]              dist_out,
   output logic [IDX_W-1:0]           idx_out,
   output logic [TW-1:0]              track_out,
   output logic [sstf_pkg::OWNER_W-1:0] owner_out
);

   logic [TW-1:0]                track_ff;
   logic [sstf_pkg::OWNER_W-1:0] owner_ff;
   sstf_pkg::scan_ctl_type       ctl_ff, ctl_in_w;
   logic [TW-1:0]                dist_ff, dist_in_w;
   logic [IDX_W-1:0]             idx_ff, idx_in_w;
   logic [TW-1:0]                btrack_ff, btrack_in;
   logic [sstf_pkg::OWNER_W-1:0] bowner_ff, bowner_in;
   logic [TW-1:0]                own_dist;
   logic                         take;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         track_ff <= wr_track;
         owner_ff <= wr_owner;
      end else if (shift_en) begin
         track_ff <= nxt_track;
         owner_ff <= nxt_owner;
      end
   end

   // strict compare keeps the older entry on a tie
   always_comb begin
      own_dist = (track_ff >= head) ? (track_ff - head) : (head - track_ff);
      take     = occupied && (!ctl_in.found || (own_dist < dist_in));
      ctl_in_w.valid = ctl_in.valid;
      ctl_in_w.found = ctl_in.found || take;
      dist_in_w = take ? own_dist : dist_in;
      idx_in_w  = take ? IDX_W'(CELL_INDEX) : idx_in;
      btrack_in = take ? track_ff : track_in;
      bowner_in = take ? owner_ff : owner_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_w;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff   <= dist_in_w;
      idx_ff    <= idx_in_w;
      btrack_ff <= btrack_in;
      bowner_ff <= bowner_in;
   end

   assign entry_track = track_ff;
   assign entry_owner = owner_ff;
   assign ctl_out     = ctl_ff;
   assign dist_out    = dist_ff;
   assign idx_out     = idx_ff;
   assign track_out   = btrack_ff;
   assign owner_out   = bowner_ff;

endmodule

// ----- rtl/sstf_checker.sv -----
// sstf_checker: port-level checks of the scheduler over time, bound to the top level
// depends on sstf_pkg and sstf_disk_request_scheduler_unit
module sstf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sstf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an accepted request never produces a result in the next cycle
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result too early after request");

   // one request at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind sstf_disk_request_scheduler_unit sstf_checker u_checker (.*);
